// ===== hdl/mcd_pkg.sv =====
// Shared constants and helpers for the magnetometer calibrate/decimate core.
package mcd_pkg;

  localparam int unsigned AxisW     = 16;
  localparam int unsigned ProdW     = 32;
  localparam int unsigned CfgW      = 48;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned SkipW     = 17;
  localparam int unsigned LimitW    = 16;
  localparam int unsigned SampleDef = 16;

  localparam logic [CfgIdxW-1:0] RegBias  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSkip  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegNumX  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegNumY  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegNumZ  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDenX  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDenY  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegDenZ  = 3'd7;

  // Request to the serial divider.
  typedef struct packed {
    logic                    start;
    logic [ProdW-1:0]        dividend_mag;
    logic [AxisW-1:0]        divisor_mag;
    logic                    negate;
  } div_req_t;

  // Answer from the serial divider.
  typedef struct packed {
    logic                    done;
    logic signed [ProdW-1:0] quotient;
  } div_rsp_t;

  function automatic logic [AxisW-1:0] lane(input logic [CfgW-1:0] pack,
                                            input logic [1:0] k);
    logic [AxisW-1:0] r;
    begin
      unique case (k)
        2'd0:    r = pack[15:0];
        2'd1:    r = pack[31:16];
        default: r = pack[47:32];
      endcase
      return r;
    end
  endfunction

endpackage

// ===== hdl/mcd_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle, signed result.
module mcd_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mcd_pkg::div_req_t req_i,
  output mcd_pkg::div_rsp_t rsp_o
);

  localparam int unsigned PW = mcd_pkg::ProdW;
  localparam int unsigned CntW = $clog2(PW + 1);

  logic [PW-1:0]              quo_q, quo_d;
  logic [mcd_pkg::AxisW:0]    rem_q, rem_d;
  logic [mcd_pkg::AxisW-1:0]  dvs_q, dvs_d;
  logic                       neg_q, neg_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [mcd_pkg::AxisW:0]    trial;
  logic [mcd_pkg::AxisW+1:0]  diff;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[mcd_pkg::AxisW-1:0], quo_q[PW-1]};
    diff   = {1'b0, trial} - {2'b00, dvs_q};
    if (req_i.start) begin
      quo_d  = req_i.dividend_mag;
      rem_d  = '0;
      dvs_d  = req_i.divisor_mag;
      neg_d  = req_i.negate;
      cnt_d  = CntW'(PW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[mcd_pkg::AxisW+1]) begin
        rem_d = diff[mcd_pkg::AxisW:0];
        quo_d = {quo_q[PW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[PW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

// ===== hdl/magnetometer_calibrate_decimate_core.sv =====
// Top level of the magnetometer calibrate/decimate core.
// One six-byte burst per input item. A skip counter decimates: while it is
// not above skip_limit the item is absorbed with no result. Otherwise the
// core subtracts the biases, then computes nine terms axis*num/den one
// after another on a shared bit-serial divider (one quotient bit per
// cycle, with setup and accumulate states StMul and StOut per term). Zero
// denominators skip the divider. Sums wrap to 16 bits. One item is worked
// at a time; the result sits in an output register until taken. While it
// waits, a burst that only advances the skip counter is still accepted, but
// one that would produce a result waits until the old result is taken.
// Configuration is written through a plain write port; the user must write
// it only while idle, as the block itself does not enforce it.
module magnetometer_calibrate_decimate_core #(
  parameter int unsigned SAMPLE_BITS = mcd_pkg::SampleDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mcd_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [mcd_pkg::CfgW-1:0]          cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        x_high_byte_i,
  input  logic [7:0]                        x_low_byte_i,
  input  logic [7:0]                        z_high_byte_i,
  input  logic [7:0]                        z_low_byte_i,
  input  logic [7:0]                        y_high_byte_i,
  input  logic [7:0]                        y_low_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [mcd_pkg::AxisW-1:0]  field_x_o,
  output logic signed [mcd_pkg::AxisW-1:0]  field_y_o,
  output logic signed [mcd_pkg::AxisW-1:0]  field_z_o
);

  localparam int unsigned AW = mcd_pkg::AxisW;
  localparam int unsigned PW = mcd_pkg::ProdW;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  // configuration
  logic [mcd_pkg::CfgW-1:0]   bias_q;
  logic [mcd_pkg::LimitW-1:0] limit_q;
  logic [mcd_pkg::CfgW-1:0]   num_q [3];
  logic [mcd_pkg::CfgW-1:0]   den_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q  <= '0;
      limit_q <= '0;
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= '0;
        den_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mcd_pkg::RegBias: bias_q   <= cfg_data_i;
        mcd_pkg::RegSkip: limit_q  <= cfg_data_i[mcd_pkg::LimitW-1:0];
        mcd_pkg::RegNumX: num_q[0] <= cfg_data_i;
        mcd_pkg::RegNumY: num_q[1] <= cfg_data_i;
        mcd_pkg::RegNumZ: num_q[2] <= cfg_data_i;
        mcd_pkg::RegDenX: den_q[0] <= cfg_data_i;
        mcd_pkg::RegDenY: den_q[1] <= cfg_data_i;
        default:          den_q[2] <= cfg_data_i;
      endcase
    end
  end

  // raw sample: low SAMPLE_BITS of the 16-bit word, sign-extended
  function automatic logic [AW-1:0] raw(input logic [7:0] hi, input logic [7:0] lo);
    logic [AW-1:0] w;
    logic [AW-1:0] r;
    begin
      w = {hi, lo};
      for (int b = 0; b < AW; b++)
        r[b] = (b < SAMPLE_BITS) ? w[b] : w[SAMPLE_BITS-1];
      return r;
    end
  endfunction

  logic [1:0]          st_q, st_d;
  logic [mcd_pkg::SkipW-1:0] skip_q, skip_d;
  logic [AW-1:0]       axis_q [3];
  logic [AW-1:0]       axis_d [3];
  logic [1:0]          row_q, row_d, col_q, col_d;
  logic signed [AW-1:0] acc_q, acc_d;
  logic signed [AW-1:0] res_q [3];
  logic                out_v_q, out_v_d;
  logic signed [PW-1:0] prod_q;
  logic [AW-1:0]       den_cur_q;
  logic signed [AW-1:0] term_q;
  logic                last_term;
  mcd_pkg::div_req_t   dreq;
  mcd_pkg::div_rsp_t   drsp;
  logic                accept, emit;

  mcd_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  assign in_ready_o = (st_q == StIdle) && (!out_v_q || out_ready_i || skip_q <= {1'b0, limit_q});
  assign accept     = in_valid_i && in_ready_o;
  assign emit       = accept && (skip_q > {1'b0, limit_q});
  assign last_term  = (col_q == 2'd2);

  // bias-corrected axes, taken straight from the burst on the accepting edge
  always_comb begin
    for (int i = 0; i < 3; i++) axis_d[i] = axis_q[i];
    if (emit) begin
      axis_d[0] = raw(x_high_byte_i, x_low_byte_i) - bias_q[15:0];
      axis_d[1] = raw(y_high_byte_i, y_low_byte_i) - bias_q[31:16];
      axis_d[2] = raw(z_high_byte_i, z_low_byte_i) - bias_q[47:32];
    end
  end

  always_comb begin
    dreq.start        = (st_q == StMul) && (den_cur_q != '0);
    dreq.dividend_mag = prod_q[PW-1] ? -prod_q : prod_q;
    dreq.divisor_mag  = den_cur_q[AW-1] ? -den_cur_q : den_cur_q;
    dreq.negate       = prod_q[PW-1] ^ den_cur_q[AW-1];
  end

  always_comb begin
    st_d    = st_q;
    skip_d  = skip_q;
    row_d   = row_q;
    col_d   = col_q;
    acc_d   = acc_q;
    out_v_d = out_v_q && !out_ready_i;
    unique case (st_q)
      StIdle: begin
        if (accept) begin
          if (emit) begin
            skip_d = '0;
            st_d   = StMul;
            row_d  = 2'd0;
            col_d  = 2'd0;
            acc_d  = '0;
          end else begin
            skip_d = skip_q + 1'b1;
          end
        end
      end
      StMul: begin
        if (den_cur_q == '0) begin
          st_d = StOut;
        end else begin
          st_d = StDiv;
        end
      end
      StDiv: begin
        if (drsp.done) st_d = StOut;
      end
      default: begin
        st_d = StMul;
      end
    endcase
    // StOut: accumulate the term, then step to the next or end the item
    if (st_q == StOut) begin
      acc_d = '0;
      col_d = col_q + 1'b1;
      if (last_term) begin
        col_d = 2'd0;
        row_d = row_q + 1'b1;
        if (row_q == 2'd2) begin
          st_d    = StIdle;
          out_v_d = 1'b1;
        end
      end else begin
        acc_d = acc_q + term_q;
      end
    end
  end

  // term captured when the divider finishes or skipped as zero
  always_ff @(posedge clk_i) begin
    if (st_q == StMul && den_cur_q == '0) term_q <= '0;
    else if (drsp.done) term_q <= drsp.quotient[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      skip_q  <= '0;
      out_v_q <= 1'b0;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      st_q    <= st_d;
      skip_q  <= skip_d;
      out_v_q <= out_v_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    for (int i = 0; i < 3; i++) axis_q[i] <= axis_d[i];
    // product registered ahead of the divider
    if (st_d == StMul) begin
      prod_q    <= $signed(axis_d[col_d]) * $signed(mcd_pkg::lane(num_q[row_d], col_d));
      den_cur_q <= mcd_pkg::lane(den_q[row_d], col_d);
    end
    if (st_q == StOut && last_term) res_q[row_q] <= acc_q + term_q;
  end

  assign out_valid_o = out_v_q;
  assign field_x_o   = res_q[0];
  assign field_y_o   = res_q[1];
  assign field_z_o   = res_q[2];

endmodule

// ===== hdl/mcd_checker.sv =====
// Port-level checks for the magnetometer calibrate/decimate core.
module mcd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic [15:0] field_x_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(field_x_o))
    else $error("result dropped while stalled");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a calculation");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result after reset");

endmodule

bind magnetometer_calibrate_decimate_core mcd_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .field_x_o(field_x_o)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the magnetometer calibrate/decimate core.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles   = 400;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic [mcd_pkg::CfgIdxW-1:0]       cfg_idx_i;
  logic [mcd_pkg::CfgW-1:0]          cfg_data_i;
  logic                              in_valid_i;
  logic                              in_ready_o;
  logic [7:0]                        x_high_byte_i, x_low_byte_i;
  logic [7:0]                        z_high_byte_i, z_low_byte_i;
  logic [7:0]                        y_high_byte_i, y_low_byte_i;
  logic                              out_valid_o;
  logic                              out_ready_i;
  logic signed [mcd_pkg::AxisW-1:0]  field_x_o, field_y_o, field_z_o;

  magnetometer_calibrate_decimate_core dut (.*);

  // One calibrated output item.
  typedef struct packed {
    logic signed [mcd_pkg::AxisW-1:0] fx;
    logic signed [mcd_pkg::AxisW-1:0] fy;
    logic signed [mcd_pkg::AxisW-1:0] fz;
  } field_t;

  // Shadow of the configuration and the decimation state.
  logic [mcd_pkg::CfgW-1:0]   bias_shadow;
  logic [mcd_pkg::LimitW-1:0] skip_shadow;
  logic [mcd_pkg::CfgW-1:0]   num_shadow [3];
  logic [mcd_pkg::CfgW-1:0]   den_shadow [3];
  logic [mcd_pkg::SkipW-1:0]  decim_count;

  field_t field_queue [$];
  int     error_count;
  int     idle_cycles;
  int     send_idle_pct;
  int     take_idle_pct;
  bit     timed_out;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic signed [mcd_pkg::AxisW-1:0] lane_of(logic [mcd_pkg::CfgW-1:0] pack,
                                                               int k);
    return pack[16*k +: 16];
  endfunction

  // One row: sum of axis*num/den, truncating toward zero, zero den gives 0.
  function automatic logic signed [mcd_pkg::AxisW-1:0] calib_sum(int row,
                                                                 longint ax [3]);
    longint acc;
    longint n, d;
    acc = 0;
    for (int k = 0; k < 3; k++) begin
      n = longint'(lane_of(num_shadow[row], k));
      d = longint'(lane_of(den_shadow[row], k));
      if (d != 0) acc += (ax[k] * n) / d;
    end
    return acc[15:0];
  endfunction

  // Advance the decimator for one accepted burst; queue a result if due.
  task automatic predict_burst(logic [7:0] xh, xl, zh, zl, yh, yl);
    longint ax [3];
    logic signed [mcd_pkg::AxisW-1:0] t;
    field_t f;
    if ({15'd0, decim_count} <= {16'd0, skip_shadow}) begin
      decim_count = decim_count + 1'b1;
      return;
    end
    decim_count = '0;
    t = $signed({xh, xl}) - lane_of(bias_shadow, 0);
    ax[0] = longint'(t);
    t = $signed({yh, yl}) - lane_of(bias_shadow, 1);
    ax[1] = longint'(t);
    t = $signed({zh, zl}) - lane_of(bias_shadow, 2);
    ax[2] = longint'(t);
    f.fx = calib_sum(0, ax);
    f.fy = calib_sum(1, ax);
    f.fz = calib_sum(2, ax);
    field_queue.push_back(f);
  endtask

  // Register write, only while idle; write enable drops again before the task returns.
  task automatic write_reg(logic [mcd_pkg::CfgIdxW-1:0] idx, logic [mcd_pkg::CfgW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      mcd_pkg::RegBias: bias_shadow = data;
      mcd_pkg::RegSkip: skip_shadow = data[mcd_pkg::LimitW-1:0];
      mcd_pkg::RegNumX: num_shadow[0] = data;
      mcd_pkg::RegNumY: num_shadow[1] = data;
      mcd_pkg::RegNumZ: num_shadow[2] = data;
      mcd_pkg::RegDenX: den_shadow[0] = data;
      mcd_pkg::RegDenY: den_shadow[1] = data;
      default:          den_shadow[2] = data;
    endcase
    @(negedge clk_i);
  endtask

  // Send one burst; valid holds until accepted. Valid drops on idle cycles
  // here or in wait_idle, so back-to-back items keep it high.
  task automatic send_burst(logic [7:0] xh, xl, zh, zl, yh, yl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    x_high_byte_i <= xh; x_low_byte_i <= xl;
    z_high_byte_i <= zh; z_low_byte_i <= zl;
    y_high_byte_i <= yh; y_low_byte_i <= yl;
    do @(posedge clk_i); while (!in_ready_o);
    predict_burst(xh, xl, zh, zl, yh, yl);
    @(negedge clk_i);
  endtask

  task automatic send_random_burst();
    send_burst(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom), 8'($urandom));
  endtask

  // Wait until every result has arrived, then let the core settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (field_queue.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic logic [mcd_pkg::CfgW-1:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  // Denominators: half small magnitudes, some zero, some full range or -32768.
  function automatic logic [mcd_pkg::AxisW-1:0] rand_den();
    case ($urandom_range(5))
      0:       return '0;
      1:       return 16'($urandom);
      2:       return 16'h8000;
      default: return 16'($signed($urandom_range(32)) - 16);
    endcase
  endfunction

  task automatic load_matrix(bit wide);
    for (int r = 0; r < 3; r++) begin
      write_reg(mcd_pkg::CfgIdxW'(mcd_pkg::RegNumX + r), rand48());
      write_reg(mcd_pkg::CfgIdxW'(mcd_pkg::RegDenX + r),
                wide ? rand48() : {rand_den(), rand_den(), rand_den()});
    end
    write_reg(mcd_pkg::RegBias, rand48());
  endtask

  // Result checker: sample on rising edge, receiver stalls on the falling.
  always @(posedge clk_i) begin
    field_t exp_f;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (field_queue.size() == 0) begin
        $display("%0t unexpected result x=%0d y=%0d z=%0d", $time,
                 field_x_o, field_y_o, field_z_o);
        error_count++;
      end else begin
        exp_f = field_queue.pop_front();
        if (field_x_o !== exp_f.fx) begin
          $display("%0t field_x exp %0d got %0d", $time, exp_f.fx, field_x_o);
          error_count++;
        end
        if (field_y_o !== exp_f.fy) begin
          $display("%0t field_y exp %0d got %0d", $time, exp_f.fy, field_y_o);
          error_count++;
        end
        if (field_z_o !== exp_f.fz) begin
          $display("%0t field_z exp %0d got %0d", $time, exp_f.fz, field_z_o);
          error_count++;
        end
      end
    end
  end

  always @(negedge clk_i)
    out_ready_i <= ($urandom_range(99) >= take_idle_pct);

  // Watchdog: cycles with no item moved on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Directed: identity matrix, byte extremes, bias wrap, zero den, skip.
  task automatic test_directed();
    write_reg(mcd_pkg::RegSkip, '0);
    write_reg(mcd_pkg::RegNumX, 48'h0000_0000_0001);
    write_reg(mcd_pkg::RegNumY, 48'h0000_0001_0000);
    write_reg(mcd_pkg::RegNumZ, 48'h0001_0000_0000);
    write_reg(mcd_pkg::RegDenX, 48'h0001_0001_0001);
    write_reg(mcd_pkg::RegDenY, 48'h0001_0001_0001);
    write_reg(mcd_pkg::RegDenZ, 48'h0001_0001_0001);
    write_reg(mcd_pkg::RegBias, '0);
    send_burst(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_burst(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_burst(8'h7F, 8'hFF, 8'h80, 8'h00, 8'h7F, 8'hFF);
    send_burst(8'h80, 8'h00, 8'h7F, 8'hFF, 8'h80, 8'h00);
    send_burst(8'hAA, 8'h55, 8'h55, 8'hAA, 8'h0F, 8'hF0);
    wait_idle();
    // bias wraps; full-range products and dens, -32768/-1 style cases
    write_reg(mcd_pkg::RegBias, 48'h8000_7FFF_8000);
    write_reg(mcd_pkg::RegNumX, 48'h8000_7FFF_8000);
    write_reg(mcd_pkg::RegNumY, 48'h7FFF_8000_FFFF);
    write_reg(mcd_pkg::RegNumZ, 48'h1234_8000_7FFF);
    write_reg(mcd_pkg::RegDenX, 48'hFFFF_0000_FFFF);
    write_reg(mcd_pkg::RegDenY, 48'h0001_8000_7FFF);
    write_reg(mcd_pkg::RegDenZ, 48'h0000_0003_FFFD);
    send_burst(8'h7F, 8'hFF, 8'h80, 8'h00, 8'h80, 8'h00);
    send_burst(8'h80, 8'h00, 8'h7F, 8'hFF, 8'h7F, 8'hFF);
    send_burst(8'h00, 8'h01, 8'hFF, 8'hFE, 8'h00, 8'h00);
    wait_idle();
    // all-zero dens; the one burst here is absorbed by the decimator and gives no result
    for (int r = 0; r < 3; r++) write_reg(mcd_pkg::CfgIdxW'(mcd_pkg::RegDenX + r), '0);
    send_burst(8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC);
    wait_idle();
    // decimation: skip 3, eight items, one result
    write_reg(mcd_pkg::RegDenZ, 48'h0005_FFF9_0002);
    write_reg(mcd_pkg::RegSkip, 48'd3);
    repeat (8) send_random_burst();
    wait_idle();
  endtask

  // Random phase under one idling profile, resetting the matrix each round.
  task automatic test_random(int rounds, int per_round);
    for (int i = 0; i < rounds; i++) begin
      load_matrix($urandom_range(3) == 0);
      write_reg(mcd_pkg::RegSkip, $urandom_range(1) ? 48'd0 : 48'($urandom_range(3)));
      repeat (per_round) send_random_burst();
      wait_idle();
    end
  endtask

  // Largest skip limit (0xFFFF): the bursts sent are all absorbed, then the limit returns to zero.
  task automatic test_skip_extremes();
    write_reg(mcd_pkg::RegSkip, 48'hFFFF);
    decim_count = decim_count;
    repeat (3) send_random_burst();
    wait_idle();
    write_reg(mcd_pkg::RegSkip, '0);
  endtask

  initial begin
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0; out_ready_i = 1'b0;
    x_high_byte_i = '0; x_low_byte_i = '0; z_high_byte_i = '0;
    z_low_byte_i = '0; y_high_byte_i = '0; y_low_byte_i = '0;
    bias_shadow = '0; skip_shadow = '0; decim_count = '0;
    for (int r = 0; r < 3; r++) begin
      num_shadow[r] = '0;
      den_shadow[r] = '0;
    end
    error_count = 0; idle_cycles = 0; timed_out = 1'b0;
    send_idle_pct = 0; take_idle_pct = 0;
    rst_ni = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    send_idle_pct = 11; take_idle_pct = 72;
    test_random(15, 30);
    test_skip_extremes();
    send_idle_pct = 72; take_idle_pct = 11;
    test_random(15, 30);
    send_idle_pct = 0; take_idle_pct = 0;
    test_random(15, 30);

    if (error_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== magnetometer_calibrate_decimate_core.f =====
hdl/mcd_pkg.sv
hdl/mcd_div.sv
hdl/magnetometer_calibrate_decimate_core.sv
hdl/mcd_checker.sv
tb/tb_top.sv
